// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms; they compile to nothing when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Checked at every rising edge while reset is released.
`define ASSERT_RST(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
// Checked at every rising edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define ASSERT_RST(lbl, clk, rst_n, prop)
`define ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// ===== rtl/fat12ct_pkg.sv =====
// ----------------------------------------------------------------------------
// fat12ct_pkg
// Types and constants shared by the FAT12 cluster table engine modules.
// ----------------------------------------------------------------------------
package fat12ct_pkg;

    localparam int KIND_W    = 3;
    localparam int CLUSTER_W = 10;
    localparam int LINK_W    = 12;
    localparam int USABLE_W  = 10;

    localparam logic [KIND_W-1:0] KIND_READ   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_WRITE  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_FREE   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_FIRST  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_SECOND = 3'd4;
    localparam logic [KIND_W-1:0] KIND_COUNT  = 3'd5;

    localparam logic [LINK_W-1:0]   END_MARK     = 12'hFFF;
    localparam logic [LINK_W-1:0]   MEDIA_LINK   = 12'hFF9;
    localparam logic [LINK_W-1:0]   FREE_LINK    = 12'h000;
    localparam logic [USABLE_W-1:0] USABLE_RESET = 10'd713;

    typedef enum logic [2:0] {
        OP_READ,
        OP_WRITE,
        OP_FREE,
        OP_FIRST,
        OP_SECOND,
        OP_COUNT,
        OP_NONE
    } op_t;

    typedef struct packed {
        op_t                  op;
        logic                 in_range;
        logic [CLUSTER_W-1:0] cluster;
        logic [LINK_W-1:0]    link;
    } cmd_t;

    typedef struct packed {
        logic clearing;
    } eng_status_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_FREE_RD,
        ST_FREE_EV,
        ST_SCAN,
        ST_RESULT
    } eng_state_t;

endpackage

// ===== rtl/fat12ct_front.sv =====
// ----------------------------------------------------------------------------
// fat12ct_front
// Accepts input transfers, decodes the kind and range-checks the cluster.
// ----------------------------------------------------------------------------
module fat12ct_front import fat12ct_pkg::*; #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [23:0]          s_tdata,
    input  logic [KIND_W-1:0]    s_tuser,
    input  eng_status_t          status,
    input  logic                 q_full,
    output logic                 q_push,
    output cmd_t                 q_cmd
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = (AW + 1 > 11) ? AW + 1 : 11;

    logic [CW-1:0] cluster_ext;

    // No transfer is taken while the table is being initialized.
    assign s_tready = !q_full && !status.clearing;
    assign q_push   = s_tvalid && s_tready;

    assign cluster_ext = CW'(s_tdata[CLUSTER_W-1:0]);

    always_comb begin
        q_cmd.cluster  = s_tdata[CLUSTER_W-1:0];
        q_cmd.link     = s_tdata[CLUSTER_W+LINK_W-1:CLUSTER_W];
        q_cmd.in_range = cluster_ext < CW'(TABLE_DEPTH);
        case (s_tuser)
            KIND_READ:   q_cmd.op = OP_READ;
            KIND_WRITE:  q_cmd.op = OP_WRITE;
            KIND_FREE:   q_cmd.op = OP_FREE;
            KIND_FIRST:  q_cmd.op = OP_FIRST;
            KIND_SECOND: q_cmd.op = OP_SECOND;
            KIND_COUNT:  q_cmd.op = OP_COUNT;
            default:     q_cmd.op = OP_NONE;
        endcase
    end

endmodule

// ===== rtl/fat12ct_queue.sv =====
// ----------------------------------------------------------------------------
// fat12ct_queue
// Two-entry command queue between the decode front and the table engine.
// ----------------------------------------------------------------------------
module fat12ct_queue import fat12ct_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic head_valid,
    output cmd_t head_cmd
);

    cmd_t       entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full       = count_reg == 2'd2;
    assign head_valid = count_reg != 2'd0;
    assign head_cmd   = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = !wr_ptr_reg;
        end
        if (pop) begin
            rd_ptr_next = !rd_ptr_reg;
        end
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== rtl/fat12ct_engine.sv =====
// ----------------------------------------------------------------------------
// fat12ct_engine
// Holds the link table memory and carries out one command at a time.
// ----------------------------------------------------------------------------
module fat12ct_engine import fat12ct_pkg::*; #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [USABLE_W-1:0] cfg_wr_data,
    input  logic                cmd_valid,
    input  cmd_t                cmd,
    output logic                cmd_pop,
    output eng_status_t         status,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [15:0]         m_tdata,
    output logic [1:0]          m_tuser
);

    localparam int AW = $clog2(TABLE_DEPTH);
    // Wide enough for any 12-bit link and for TABLE_DEPTH itself.
    localparam int CW = (AW + 1 > LINK_W) ? AW + 1 : LINK_W;

    logic [LINK_W-1:0] mem [TABLE_DEPTH];
    logic [LINK_W-1:0] rdata_reg;
    logic              mem_we, mem_re;
    logic [AW-1:0]     mem_wa, mem_ra;
    logic [LINK_W-1:0] mem_wd;

    eng_state_t          state_reg, state_next;
    logic [AW-1:0]       clr_idx_reg, clr_idx_next;
    op_t                 op_reg, op_next;
    logic [LINK_W-1:0]   cur_reg, cur_next;
    logic [AW-1:0]       steps_reg, steps_next;
    logic [CW-1:0]       issue_reg, issue_next;
    logic                pend_reg, pend_next;
    logic [AW-1:0]       pidx_reg, pidx_next;
    logic [USABLE_W-1:0] cnt_reg, cnt_next;
    logic                seen_reg, seen_next;
    logic [LINK_W-1:0]   res_data_reg, res_data_next;
    logic                res_found_reg, res_found_next;
    logic                res_err_reg, res_err_next;
    logic [USABLE_W-1:0] usable_reg;

    logic                m_tvalid_reg;
    logic [LINK_W-1:0]   m_data_reg;
    logic                m_found_reg, m_err_reg;
    logic                out_load;

    logic [CW-1:0]       cmd_cl_ext;
    logic [CW-1:0]       cur_ext;
    logic [CW-1:0]       scan_sum, scan_limit;
    logic                issue_ok;

    assign cmd_cl_ext = CW'(cmd.cluster);
    assign cur_ext    = CW'(cur_reg);
    assign scan_sum   = CW'(usable_reg) + CW'(2);
    assign scan_limit = (scan_sum > CW'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH) : scan_sum;
    assign issue_ok   = issue_reg < scan_limit;

    assign status.clearing = state_reg == ST_CLEAR;

    always_comb begin
        state_next     = state_reg;
        clr_idx_next   = clr_idx_reg;
        op_next        = op_reg;
        cur_next       = cur_reg;
        steps_next     = steps_reg;
        issue_next     = issue_reg;
        pend_next      = pend_reg;
        pidx_next      = pidx_reg;
        cnt_next       = cnt_reg;
        seen_next      = seen_reg;
        res_data_next  = res_data_reg;
        res_found_next = res_found_reg;
        res_err_next   = res_err_reg;
        cmd_pop        = 1'b0;
        mem_we         = 1'b0;
        mem_wa         = clr_idx_reg;
        mem_wd         = FREE_LINK;
        mem_re         = 1'b0;
        mem_ra         = cmd_cl_ext[AW-1:0];
        out_load       = 1'b0;

        case (state_reg)
            ST_CLEAR: begin
                // One entry per cycle: the two system entries get their marks.
                mem_we = 1'b1;
                if (clr_idx_reg == AW'(0)) begin
                    mem_wd = MEDIA_LINK;
                end else if (clr_idx_reg == AW'(1)) begin
                    mem_wd = END_MARK;
                end
                clr_idx_next = clr_idx_reg + AW'(1);
                if (clr_idx_reg == AW'(TABLE_DEPTH - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                res_data_next  = '0;
                res_found_next = 1'b0;
                res_err_next   = 1'b0;
                if (cmd_valid) begin
                    cmd_pop = 1'b1;
                    op_next = cmd.op;
                    case (cmd.op)
                        OP_READ: begin
                            if (cmd.in_range) begin
                                mem_re     = 1'b1;
                                state_next = ST_READ;
                            end else begin
                                state_next = ST_RESULT;
                            end
                        end
                        OP_WRITE: begin
                            mem_we     = cmd.in_range;
                            mem_wa     = cmd_cl_ext[AW-1:0];
                            mem_wd     = cmd.link;
                            state_next = ST_RESULT;
                        end
                        OP_FREE: begin
                            cur_next   = LINK_W'(cmd.cluster);
                            steps_next = '0;
                            state_next = ST_FREE_RD;
                        end
                        OP_FIRST, OP_SECOND, OP_COUNT: begin
                            issue_next = CW'(2);
                            pend_next  = 1'b0;
                            cnt_next   = '0;
                            seen_next  = 1'b0;
                            state_next = ST_SCAN;
                        end
                        default: begin
                            state_next = ST_RESULT;
                        end
                    endcase
                end
            end
            ST_READ: begin
                res_data_next = rdata_reg;
                state_next    = ST_RESULT;
            end
            ST_FREE_RD: begin
                if (cur_ext < CW'(TABLE_DEPTH)) begin
                    mem_re     = 1'b1;
                    mem_ra     = cur_ext[AW-1:0];
                    state_next = ST_FREE_EV;
                end else begin
                    res_err_next = 1'b1;
                    state_next   = ST_RESULT;
                end
            end
            ST_FREE_EV: begin
                // The entry is cleared before its old link is followed.
                mem_we = 1'b1;
                mem_wa = cur_ext[AW-1:0];
                mem_wd = FREE_LINK;
                if (rdata_reg == END_MARK) begin
                    state_next = ST_RESULT;
                end else if (rdata_reg == FREE_LINK || steps_reg == AW'(TABLE_DEPTH - 1)) begin
                    res_err_next = 1'b1;
                    state_next   = ST_RESULT;
                end else begin
                    cur_next   = rdata_reg;
                    steps_next = steps_reg + AW'(1);
                    state_next = ST_FREE_RD;
                end
            end
            ST_SCAN: begin
                // Reads are issued one per cycle and each is checked against the registered read data it returns.
                pend_next = issue_ok;
                if (issue_ok) begin
                    mem_re     = 1'b1;
                    mem_ra     = issue_reg[AW-1:0];
                    pidx_next  = issue_reg[AW-1:0];
                    issue_next = issue_reg + CW'(1);
                end
                if (pend_reg && rdata_reg == FREE_LINK) begin
                    if (op_reg == OP_COUNT) begin
                        cnt_next = cnt_reg + USABLE_W'(1);
                    end else if (op_reg == OP_FIRST || seen_reg) begin
                        res_data_next  = LINK_W'(pidx_reg);
                        res_found_next = 1'b1;
                        state_next     = ST_RESULT;
                    end else begin
                        seen_next = 1'b1;
                    end
                end
                if (!pend_reg && !issue_ok) begin
                    if (op_reg == OP_COUNT) begin
                        res_data_next = LINK_W'(cnt_reg);
                    end
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT: begin
                if (!m_tvalid_reg || m_tready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_idx_reg  <= '0;
            usable_reg   <= USABLE_RESET;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_idx_reg <= clr_idx_next;
            if (cfg_wr_en) begin
                usable_reg <= cfg_wr_data;
            end
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        op_reg        <= op_next;
        cur_reg       <= cur_next;
        steps_reg     <= steps_next;
        issue_reg     <= issue_next;
        pend_reg      <= pend_next;
        pidx_reg      <= pidx_next;
        cnt_reg       <= cnt_next;
        seen_reg      <= seen_next;
        res_data_reg  <= res_data_next;
        res_found_reg <= res_found_next;
        res_err_reg   <= res_err_next;
        if (out_load) begin
            m_data_reg  <= res_data_reg;
            m_found_reg <= res_found_reg;
            m_err_reg   <= res_err_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            rdata_reg <= mem[mem_ra];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {4'b0000, m_data_reg};
    assign m_tuser  = {m_err_reg, m_found_reg};

endmodule

// ===== rtl/fat12_cluster_table_engine_unit.sv =====
// ----------------------------------------------------------------------------
// fat12_cluster_table_engine_unit
// FAT12 cluster link table with read, write, chain free, free searches and free count.
// ----------------------------------------------------------------------------
// Usage:
// Commands arrive on the s_ stream (kind in s_tuser, cluster and link in
// s_tdata); every command gives exactly one result transfer on the m_ stream.
// The user writes usable_clusters through cfg_wr_en / cfg_wr_data only while idle;
// the block does not enforce it. A decode front feeds a two-entry queue, so up to
// two commands are taken while the engine is busy or its result waits in the
// output register. A chain free reads and then clears each entry in turn,
// following its links; it stops at the end mark, or with chain_error at a cluster
// outside the table, a free link or a chain longer than the table. A count, or a
// search, reads its clusters in order; a search stops early when it finds its cluster.
// Searches cover clusters 2 up to usable_clusters+1, capped at the table end.
// Reset (aresetn low, synchronous) starts a clearing pass that writes every
// entry; s_tready stays low until it is done.
// When the receiver stalls, the result holds in the output register, the
// engine finishes the next command and waits, then the queue fills and
// s_tready drops.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fat12_cluster_table_engine_unit import fat12ct_pkg::*; #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [USABLE_W-1:0] cfg_wr_data,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [23:0]         s_tdata,   // [9:0] cluster, [21:10] link_value, zero pad
    input  logic [KIND_W-1:0]   s_tuser,   // [2:0] kind
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [15:0]         m_tdata,   // [11:0] data, zero pad
    output logic [1:0]          m_tuser    // [0] found, [1] chain_error
);

    eng_status_t status;
    logic        q_full, q_push, q_pop, q_valid;
    cmd_t        q_in_cmd, q_head_cmd;

    fat12ct_front #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_front (
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .status  (status),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_cmd   (q_in_cmd)
    );

    fat12ct_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_cmd  (q_in_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .head_valid(q_valid),
        .head_cmd  (q_head_cmd)
    );

    fat12ct_engine #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_engine (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .cmd_valid  (q_valid),
        .cmd        (q_head_cmd),
        .cmd_pop    (q_pop),
        .status     (status),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

    `ASSERT_RST(a_no_accept_while_clearing, aclk, aresetn, status.clearing |-> !s_tready)
    `ASSERT_ALWAYS(a_clear_follows_reset, aclk, !aresetn |=> status.clearing)
    `ASSERT_RST(a_error_result_is_plain, aclk, aresetn,
        m_tvalid && m_tuser[1] |-> !m_tuser[0] && m_tdata[11:0] == 12'h000)
    `ASSERT_RST(a_pop_only_when_queued, aclk, aresetn, q_pop |-> q_valid && !status.clearing)

endmodule
